// ----- rtl/core/i2csm_pkg.sv -----
package i2csm_pkg;

   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 16;

   localparam logic [7:0]  WRITE_ADDRESS_RST    = 8'hB0;
   localparam logic [7:0]  READ_ADDRESS_RST     = 8'hB1;
   localparam logic [7:0]  PHASE_TICKS_RST      = 8'd2;
   localparam logic [7:0]  ACK_POLL_LIMIT_RST   = 8'd250;
   localparam logic [15:0] POST_WRITE_TICKS_RST = 16'd10000;

   // last bit of a byte and index of the final read byte
   localparam logic [2:0] LAST_BIT       = 3'd7;
   localparam logic [2:0] LAST_CMD_BYTE  = 3'd2;
   localparam logic [2:0] CRC_BYTE       = 3'd2;
   localparam logic [2:0] LAST_READ_BYTE = 3'd4;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_RSVD  = 2'd3
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_WRITE_ADDRESS    = 3'd0,
      REG_READ_ADDRESS     = 3'd1,
      REG_PHASE_TICKS      = 3'd2,
      REG_ACK_POLL_LIMIT   = 3'd3,
      REG_POST_WRITE_TICKS = 3'd4
   } reg_index_type;

   typedef enum logic [4:0] {
      S_IDLE = 5'd0,
      S_ST0  = 5'd1,
      S_ST1  = 5'd2,
      S_TXA  = 5'd3,
      S_TXB  = 5'd4,
      S_TXC  = 5'd5,
      S_TXT  = 5'd6,
      S_AW   = 5'd7,
      S_AP   = 5'd8,
      S_TO0  = 5'd9,
      S_TO1  = 5'd10,
      S_SP0  = 5'd11,
      S_SP1  = 5'd12,
      S_RXA  = 5'd13,
      S_RXB  = 5'd14,
      S_RK0  = 5'd15,
      S_RK1  = 5'd16,
      S_HOLD = 5'd17
   } phase_type;

endpackage

// ----- rtl/core/i2csm_if.sv -----
interface i2csm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] cmd_first;
   logic [7:0] cmd_second;
   logic       sda_in;

   modport source (output valid, opcode, cmd_first, cmd_second, sda_in, input ready);
   modport sink   (input valid, opcode, cmd_first, cmd_second, sda_in, output ready);
endinterface

interface i2csm_rsp_if;
   logic        valid;
   logic        ready;
   logic        scl_level;
   logic        sda_level;
   logic        sda_drive;
   logic        busy_res;
   logic        done_res;
   logic        ack_error;
   logic [31:0] read_value;

   modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                   ack_error, read_value, input ready);
   modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
                   ack_error, read_value, output ready);
endinterface

interface i2csm_csr_if;
   import i2csm_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/i2c_sensor_master.sv -----
// I2C master bit engine for a two-byte-command, five-byte-reading sensor. Every request
// beat is one time tick and yields exactly one response beat with the line levels for
// that tick, the busy/done flags, the acknowledge error flag and the packed read word.
// One tick is taken per clock cycle: the whole tick update is a single pass of logic
// between the state registers and the response register, so req_bus.ready stays high
// as long as the response register is empty or is being drained in the same cycle.
// Bus phase lengths, ack timeout and post-write hold are counted in ticks, not clock
// cycles. The user writes csr_bus registers only while the engine idles; not enforced.
module i2c_sensor_master
   import i2csm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   i2csm_req_if.sink     req_bus,
   i2csm_rsp_if.source   rsp_bus,
   i2csm_csr_if.sink     csr_bus
);

   logic [7:0]  write_address_ff, read_address_ff, phase_ticks_ff, ack_poll_limit_ff;
   logic [15:0] post_write_ticks_ff;

   phase_type   state_ff, state_in;
   logic [7:0]  timer_ff, timer_in;
   logic [2:0]  bit_ff, bit_in;
   logic [2:0]  byte_ff, byte_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  poll_ff, poll_in;
   logic [15:0] hold_ff, hold_in;
   logic [15:0] cmd_ff, cmd_in;
   logic [31:0] word_ff, word_in;
   logic        ackf_ff, ackf_in;
   logic        rd_ff, rd_in;
   logic        done_in;

   // state as seen after a possible transaction start in this tick
   phase_type   eff_state;
   logic [7:0]  eff_timer, eff_shift, eff_poll;
   logic [2:0]  eff_bit, eff_byte;
   logic [15:0] eff_cmd;
   logic        eff_ackf, eff_rd;

   logic [7:0]  seg_len, seg_inc, seg_timer;
   logic        seg_done;

   logic        scl_in, lvl_in, drv_in, busy_in;

   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_lvl_ff, rsp_drv_ff, rsp_busy_ff, rsp_done_ff, rsp_err_ff;
   logic [31:0] rsp_value_ff;

   logic        req_acc;
   logic        start;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         write_address_ff    <= WRITE_ADDRESS_RST;
         read_address_ff     <= READ_ADDRESS_RST;
         phase_ticks_ff      <= PHASE_TICKS_RST;
         ack_poll_limit_ff   <= ACK_POLL_LIMIT_RST;
         post_write_ticks_ff <= POST_WRITE_TICKS_RST;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            REG_WRITE_ADDRESS:    write_address_ff    <= csr_bus.data[7:0];
            REG_READ_ADDRESS:     read_address_ff     <= csr_bus.data[7:0];
            REG_PHASE_TICKS:      phase_ticks_ff      <= csr_bus.data[7:0];
            REG_ACK_POLL_LIMIT:   ack_poll_limit_ff   <= csr_bus.data[7:0];
            REG_POST_WRITE_TICKS: post_write_ticks_ff <= csr_bus.data;
            default: ;
         endcase
      end
   end

   assign start = (state_ff == S_IDLE) &&
                  (req_bus.opcode == OP_WRITE || req_bus.opcode == OP_READ);

   always_comb begin
      eff_state = state_ff;
      eff_timer = timer_ff;
      eff_shift = shift_ff;
      eff_poll  = poll_ff;
      eff_bit   = bit_ff;
      eff_byte  = byte_ff;
      eff_cmd   = cmd_ff;
      eff_ackf  = ackf_ff;
      eff_rd    = rd_ff;
      if (start) begin
         eff_rd    = (req_bus.opcode == OP_READ);
         if (!eff_rd) eff_cmd = {req_bus.cmd_first, req_bus.cmd_second};
         eff_shift = eff_rd ? read_address_ff : write_address_ff;
         eff_ackf  = 1'b0;
         eff_byte  = '0;
         eff_bit   = '0;
         eff_poll  = '0;
         eff_state = S_ST0;
         eff_timer = '0;
      end
   end

   // phase length zero counts as one
   assign seg_len   = (phase_ticks_ff == 8'd0) ? 8'd1 : phase_ticks_ff;
   assign seg_inc   = eff_timer + 8'd1;
   assign seg_done  = (seg_inc >= seg_len);
   assign seg_timer = seg_done ? 8'd0 : seg_inc;

   // next state
   always_comb begin
      state_in = eff_state;
      timer_in = eff_timer;
      shift_in = eff_shift;
      poll_in  = eff_poll;
      bit_in   = eff_bit;
      byte_in  = eff_byte;
      cmd_in   = eff_cmd;
      ackf_in  = eff_ackf;
      rd_in    = eff_rd;
      hold_in  = hold_ff;
      word_in  = word_ff;
      done_in  = 1'b0;
      unique case (eff_state)
         S_IDLE: ;
         S_ST0: begin
            timer_in = seg_timer;
            if (seg_done) state_in = S_ST1;
         end
         S_ST1: begin
            timer_in = seg_timer;
            if (seg_done) begin
               bit_in   = '0;
               state_in = S_TXA;
            end
         end
         S_TXA, S_TXB: begin
            timer_in = seg_timer;
            if (seg_done) state_in = (eff_state == S_TXA) ? S_TXB : S_TXC;
         end
         S_TXC: begin
            timer_in = seg_timer;
            if (seg_done) begin
               shift_in = {eff_shift[6:0], eff_shift[7]};
               if (eff_bit >= LAST_BIT) begin
                  state_in = S_TXT;
               end else begin
                  bit_in   = eff_bit + 3'd1;
                  state_in = S_TXA;
               end
            end
         end
         S_TXT: begin
            timer_in = seg_timer;
            if (seg_done) begin
               poll_in  = '0;
               state_in = S_AW;
            end
         end
         S_AW: begin
            timer_in = seg_timer;
            if (seg_done) state_in = S_AP;
         end
         S_AP, S_TO1: begin
            if (eff_state == S_TO1) timer_in = seg_timer;
            if ((eff_state == S_AP && !req_bus.sda_in) || (eff_state == S_TO1 && seg_done)) begin
               // acknowledge taken, or timeout stop sent: carry on with the transfer
               timer_in = '0;
               if (!eff_rd) begin
                  if (eff_byte < LAST_CMD_BYTE) begin
                     byte_in  = eff_byte + 3'd1;
                     shift_in = (eff_byte == 3'd0) ? eff_cmd[15:8] : eff_cmd[7:0];
                     bit_in   = '0;
                     state_in = S_TXA;
                  end else begin
                     state_in = S_SP0;
                  end
               end else begin
                  byte_in  = '0;
                  bit_in   = '0;
                  shift_in = '0;
                  state_in = S_RXA;
               end
            end else if (eff_state == S_AP) begin
               if (eff_poll >= ack_poll_limit_ff) begin
                  ackf_in  = 1'b1;
                  timer_in = '0;
                  state_in = S_TO0;
               end else begin
                  poll_in = eff_poll + 8'd1;
               end
            end
         end
         S_TO0, S_SP0: begin
            timer_in = seg_timer;
            if (seg_done) state_in = (eff_state == S_TO0) ? S_TO1 : S_SP1;
         end
         S_SP1: begin
            timer_in = seg_timer;
            if (seg_done) begin
               if (!eff_rd && post_write_ticks_ff != 16'd0) begin
                  hold_in  = post_write_ticks_ff;
                  state_in = S_HOLD;
               end else begin
                  done_in  = 1'b1;
                  state_in = S_IDLE;
               end
            end
         end
         S_RXA: begin
            timer_in = seg_timer;
            if (seg_done) state_in = S_RXB;
         end
         S_RXB: begin
            // sample on the first tick of the high phase
            if (eff_timer == 8'd0) shift_in = {eff_shift[6:0], req_bus.sda_in};
            timer_in = seg_timer;
            if (seg_done) begin
               if (eff_bit >= LAST_BIT) begin
                  if (eff_byte != CRC_BYTE) word_in = {word_ff[23:0], shift_in};
                  state_in = S_RK0;
               end else begin
                  bit_in   = eff_bit + 3'd1;
                  state_in = S_RXA;
               end
            end
         end
         S_RK0, S_RK1: begin
            timer_in = seg_timer;
            if (seg_done) begin
               if (eff_state == S_RK0) begin
                  state_in = S_RK1;
               end else if (eff_byte >= LAST_READ_BYTE) begin
                  state_in = S_SP0;
               end else begin
                  byte_in  = eff_byte + 3'd1;
                  bit_in   = '0;
                  shift_in = '0;
                  state_in = S_RXA;
               end
            end
         end
         S_HOLD: begin
            if (hold_ff != 16'd0) hold_in = hold_ff - 16'd1;
            if (hold_in == 16'd0) begin
               done_in  = 1'b1;
               timer_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            timer_in = '0;
            state_in = S_IDLE;
         end
      endcase
   end

   // line levels for this tick
   always_comb begin
      scl_in  = 1'b1;
      lvl_in  = 1'b1;
      drv_in  = 1'b1;
      busy_in = (eff_state != S_IDLE);
      unique case (eff_state)
         S_ST1: lvl_in = 1'b0;
         S_TXA, S_TXB, S_TXC: begin
            scl_in = (eff_state == S_TXB);
            lvl_in = eff_shift[7];
         end
         S_TXT: begin
            scl_in = 1'b0;
            lvl_in = eff_shift[0];
         end
         S_AW, S_AP, S_RXB: drv_in = 1'b0;
         S_TO0, S_SP0: begin
            scl_in = 1'b0;
            lvl_in = 1'b0;
         end
         S_RXA: begin
            scl_in = 1'b0;
            drv_in = 1'b0;
         end
         S_RK0, S_RK1: begin
            scl_in = (eff_state == S_RK1);
            lvl_in = (eff_byte >= LAST_READ_BYTE);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         timer_ff <= '0;
         bit_ff   <= '0;
         byte_ff  <= '0;
         shift_ff <= '0;
         poll_ff  <= '0;
         hold_ff  <= '0;
         cmd_ff   <= '0;
         word_ff  <= '0;
         ackf_ff  <= 1'b0;
         rd_ff    <= 1'b0;
      end else if (req_acc) begin
         state_ff <= state_in;
         timer_ff <= timer_in;
         bit_ff   <= bit_in;
         byte_ff  <= byte_in;
         shift_ff <= shift_in;
         poll_ff  <= poll_in;
         hold_ff  <= hold_in;
         cmd_ff   <= cmd_in;
         word_ff  <= word_in;
         ackf_ff  <= ackf_in;
         rd_ff    <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_scl_ff   <= scl_in;
         rsp_lvl_ff   <= lvl_in;
         rsp_drv_ff   <= drv_in;
         rsp_busy_ff  <= busy_in;
         rsp_done_ff  <= done_in;
         rsp_err_ff   <= ackf_in;
         rsp_value_ff <= word_in;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.scl_level  = rsp_scl_ff;
   assign rsp_bus.sda_level  = rsp_lvl_ff;
   assign rsp_bus.sda_drive  = rsp_drv_ff;
   assign rsp_bus.busy_res   = rsp_busy_ff;
   assign rsp_bus.done_res   = rsp_done_ff;
   assign rsp_bus.ack_error  = rsp_err_ff;
   assign rsp_bus.read_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> rsp_busy_ff)
      else $error("done beat without busy");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (req_acc && done_in) |=> (state_ff == S_IDLE))
      else $error("engine not idle after done");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_bus.ready |-> rsp_valid_ff)
      else $error("request stalled with empty response register");

   a_hold_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HOLD) |-> (hold_ff != 16'd0))
      else $error("hold state with expired timer");

   a_no_beat_frozen: assert property (@(posedge clock) disable iff (reset)
      !req_acc |=> ($stable(state_ff) && $stable(timer_ff)))
      else $error("state moved without a request beat");
`endif

endmodule
